@@ sv/spirv_lss_pkg.sv @@
`default_nettype none
package spirv_lss_pkg;

  localparam logic [31:0] MAGIC_WORD      = 32'h0723_0203;
  localparam logic [15:0] OP_EXEC_MODE    = 16'd16;
  localparam logic [31:0] MODE_LOCAL_SIZE = 32'd17;
  localparam logic [15:0] EXEC_MODE_MIN   = 16'd6;
  localparam logic [15:0] HALF_MASK       = 16'hFFFF;
  localparam logic [2:0]  HEADER_WORDS    = 3'd5;
  localparam logic [31:0] DEFAULT_SIZE    = 32'd1;

  // Operand positions inside an execution-mode instruction.
  localparam logic [2:0]  IDX_MODE        = 3'd2;
  localparam logic [2:0]  IDX_SIZE_X      = 3'd3;
  localparam logic [2:0]  IDX_SIZE_Y      = 3'd4;
  localparam logic [2:0]  IDX_SIZE_Z      = 3'd5;
  localparam logic [2:0]  IDX_SAT         = 3'd6;

  typedef struct packed {
    logic        vld;
    logic [31:0] code_word;
    logic        end_of_module;
  } in_word_t;

  typedef struct packed {
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] size_z;
    logic        found;
  } out_item_t;

endpackage
`default_nettype wire

@@ sv/spirv_lss_if.sv @@
`default_nettype none
interface spirv_lss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        end_of_module;

  modport source (output valid, output code_word, output end_of_module, input ready);
  modport sink   (input valid, input code_word, input end_of_module, output ready);
endinterface

interface spirv_lss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] size_x;
  logic [31:0] size_y;
  logic [31:0] size_z;
  logic        found;

  modport source (output valid, output size_x, output size_y, output size_z,
                  output found, input ready);
  modport sink   (input valid, input size_x, input size_y, input size_z,
                  input found, output ready);
endinterface
`default_nettype wire

@@ sv/spirv_local_size_scanner_unit.sv @@
// A final word passes through the input register and then the result register
// on its way to the output.
// Throughput: one word per cycle; the scan state updates once per word.
// A final word stalls only while the previous result has not been taken.
// Reset (rst_n low, synchronous) empties both registers and restores the
// scan state to the start of a module with default sizes of 1.
`default_nettype none
module spirv_local_size_scanner_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  spirv_lss_in_if.sink    in_chan,
  spirv_lss_out_if.source out_chan
);

  spirv_lss_pkg::in_word_t  word;
  spirv_lss_pkg::out_item_t out_item;
  logic                     take;
  logic                     in_ready;
  logic                     out_valid;

  spirv_lss_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_ready         (in_ready),
    .in_code_word     (in_chan.code_word),
    .in_end_of_module (in_chan.end_of_module),
    .take             (take),
    .word             (word)
  );

  spirv_lss_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .word      (word),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

  assign in_chan.ready   = in_ready;
  assign out_chan.valid  = out_valid;
  assign out_chan.size_x = out_item.size_x;
  assign out_chan.size_y = out_item.size_y;
  assign out_chan.size_z = out_item.size_z;
  assign out_chan.found  = out_item.found;

endmodule
`default_nettype wire

@@ sv/spirv_lss_in_stage.sv @@
`default_nettype none
module spirv_lss_in_stage (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [31:0]             in_code_word,
  input  wire logic                    in_end_of_module,
  input  wire logic                    take,
  output spirv_lss_pkg::in_word_t      word
);

  logic        vld_r, vld_nxt;
  logic [31:0] code_r;
  logic        end_r;
  logic        load;

  // The register frees up in the same cycle the core takes its word.
  assign in_ready = !vld_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= in_code_word;
      end_r  <= in_end_of_module;
    end
  end

  assign word.vld           = vld_r;
  assign word.code_word     = code_r;
  assign word.end_of_module = end_r;

endmodule
`default_nettype wire

@@ sv/spirv_lss_core.sv @@
`default_nettype none
module spirv_lss_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire spirv_lss_pkg::in_word_t  word,
  output logic                          take,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output spirv_lss_pkg::out_item_t      out_item
);

  logic [2:0]  hdr_pos_r,   hdr_pos_nxt;
  logic        magic_ok_r,  magic_ok_nxt;
  logic [15:0] left_r,      left_nxt;
  logic [2:0]  idx_r,       idx_nxt;
  logic        is_exec_r,   is_exec_nxt;
  logic        is_ls_r,     is_ls_nxt;
  logic        found_r,     found_nxt;
  logic        stopped_r,   stopped_nxt;
  logic [31:0] staged_r [3];
  logic [31:0] staged_nxt [3];
  logic [31:0] final_r [3];
  logic [31:0] final_nxt [3];
  logic        out_vld_r,   out_vld_nxt;
  spirv_lss_pkg::out_item_t out_r, out_nxt;

  logic [31:0] w;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic [2:0]  idx_inc;

  assign w        = word.code_word;
  assign len      = w[31:16] & spirv_lss_pkg::HALF_MASK;
  assign left_dec = left_r - 16'd1;
  // The index only matters up to the Z operand, so it saturates just past it.
  assign idx_inc  = (idx_r == spirv_lss_pkg::IDX_SAT) ? idx_r : idx_r + 3'd1;

  // A final word waits until the result register is free or being drained.
  assign take = word.vld && (!word.end_of_module || !out_vld_r || out_ready);

  always_comb begin
    hdr_pos_nxt  = hdr_pos_r;
    magic_ok_nxt = magic_ok_r;
    left_nxt     = left_r;
    idx_nxt      = idx_r;
    is_exec_nxt  = is_exec_r;
    is_ls_nxt    = is_ls_r;
    found_nxt    = found_r;
    stopped_nxt  = stopped_r;
    staged_nxt   = staged_r;
    final_nxt    = final_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;

    if (take) begin
      if (hdr_pos_r < spirv_lss_pkg::HEADER_WORDS) begin
        if (hdr_pos_r == 3'd0) begin
          magic_ok_nxt = (w == spirv_lss_pkg::MAGIC_WORD);
        end
        hdr_pos_nxt = hdr_pos_r + 3'd1;
      end else if (magic_ok_r && !stopped_r) begin
        if (left_r == 16'd0) begin
          if (len == 16'd0) begin
            stopped_nxt = 1'b1;
          end else begin
            left_nxt    = len - 16'd1;
            idx_nxt     = 3'd0;
            is_exec_nxt = (w[15:0] == spirv_lss_pkg::OP_EXEC_MODE) &&
                          (len >= spirv_lss_pkg::EXEC_MODE_MIN);
            is_ls_nxt   = 1'b0;
          end
        end else begin
          idx_nxt  = idx_inc;
          left_nxt = left_dec;
          case (idx_inc)
            spirv_lss_pkg::IDX_MODE:   is_ls_nxt     = (w == spirv_lss_pkg::MODE_LOCAL_SIZE);
            spirv_lss_pkg::IDX_SIZE_X: staged_nxt[0] = w;
            spirv_lss_pkg::IDX_SIZE_Y: staged_nxt[1] = w;
            spirv_lss_pkg::IDX_SIZE_Z: staged_nxt[2] = w;
            default: ;
          endcase
          if ((left_dec == 16'd0) && is_exec_r && is_ls_nxt) begin
            final_nxt   = staged_nxt;
            found_nxt   = 1'b1;
            stopped_nxt = 1'b1;
          end
        end
      end

      if (word.end_of_module) begin
        out_vld_nxt    = 1'b1;
        out_nxt.size_x = final_nxt[0];
        out_nxt.size_y = final_nxt[1];
        out_nxt.size_z = final_nxt[2];
        out_nxt.found  = found_nxt;
        // The next word starts a new module.
        hdr_pos_nxt  = 3'd0;
        magic_ok_nxt = 1'b0;
        left_nxt     = 16'd0;
        idx_nxt      = 3'd0;
        is_exec_nxt  = 1'b0;
        is_ls_nxt    = 1'b0;
        found_nxt    = 1'b0;
        stopped_nxt  = 1'b0;
        final_nxt    = '{default: spirv_lss_pkg::DEFAULT_SIZE};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r  <= 3'd0;
      magic_ok_r <= 1'b0;
      left_r     <= 16'd0;
      idx_r      <= 3'd0;
      is_exec_r  <= 1'b0;
      is_ls_r    <= 1'b0;
      found_r    <= 1'b0;
      stopped_r  <= 1'b0;
      final_r    <= '{default: spirv_lss_pkg::DEFAULT_SIZE};
      out_vld_r  <= 1'b0;
    end else begin
      hdr_pos_r  <= hdr_pos_nxt;
      magic_ok_r <= magic_ok_nxt;
      left_r     <= left_nxt;
      idx_r      <= idx_nxt;
      is_exec_r  <= is_exec_nxt;
      is_ls_r    <= is_ls_nxt;
      found_r    <= found_nxt;
      stopped_r  <= stopped_nxt;
      final_r    <= final_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Staged operands are always rewritten before an instruction can complete.
  always_ff @(posedge clk) begin
    staged_r <= staged_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

@@ sv/spirv_lss_checker.sv @@
`default_nettype none
module spirv_lss_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] size_x,
  input wire logic [31:0] size_y,
  input wire logic [31:0] size_z,
  input wire logic        found
);

  // A stalled result keeps its values.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(size_x) && $stable(size_y) &&
                                $stable(size_z) && $stable(found))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Without a find every size reports the default.
  a_default_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> size_x == 32'd1 && size_y == 32'd1 && size_z == 32'd1)
    else $error("sizes not default when nothing was found");

  // The input side only backs up behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side is free");

endmodule

bind spirv_local_size_scanner_unit spirv_lss_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .size_x    (out_chan.size_x),
  .size_y    (out_chan.size_y),
  .size_z    (out_chan.size_z),
  .found     (out_chan.found)
);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;

  spirv_lss_in_if  in_if ();
  spirv_lss_out_if out_if ();

  spirv_local_size_scanner_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow copy of the scan state, advanced once per accepted request.
  logic [2:0]       scan_hdr_pos;
  logic             scan_magic_ok;
  logic [15:0]      scan_words_left;
  logic [15:0]      scan_index;
  logic             scan_exec_mode;
  logic             scan_local_size;
  logic [2:0][31:0] scan_staged;
  logic [2:0][31:0] scan_sizes;
  logic             scan_found;
  logic             scan_stopped;

  spirv_lss_pkg::out_item_t sizes_expected_q[$];
  logic [31:0]  module_words[$];
  int           words_accepted;
  int           mismatches;
  int           idle_pct;
  int           stall_pct;
  logic         holding;
  event         hold_start;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void clear_scan_state();
    scan_hdr_pos    = '0;
    scan_magic_ok   = 1'b0;
    scan_words_left = '0;
    scan_index      = '0;
    scan_exec_mode  = 1'b0;
    scan_local_size = 1'b0;
    scan_staged     = '0;
    for (int i = 0; i < 3; i++) scan_sizes[i] = spirv_lss_pkg::DEFAULT_SIZE;
    scan_found      = 1'b0;
    scan_stopped    = 1'b0;
  endfunction

  function automatic void predict_local_size(input logic [31:0] w, input logic last);
    spirv_lss_pkg::out_item_t res;
    logic [15:0] len;
    if (scan_hdr_pos < spirv_lss_pkg::HEADER_WORDS) begin
      if (scan_hdr_pos == 3'd0) scan_magic_ok = (w == spirv_lss_pkg::MAGIC_WORD);
      scan_hdr_pos = scan_hdr_pos + 3'd1;
    end else if (scan_magic_ok && !scan_stopped) begin
      if (scan_words_left == 16'd0) begin
        len = w[31:16];
        if (len == 16'd0) begin
          scan_stopped = 1'b1;
        end else begin
          scan_words_left = len - 16'd1;
          scan_index      = '0;
          scan_exec_mode  = (w[15:0] == spirv_lss_pkg::OP_EXEC_MODE) &&
                            (len >= spirv_lss_pkg::EXEC_MODE_MIN);
          scan_local_size = 1'b0;
        end
      end else begin
        scan_index      = scan_index + 16'd1;
        scan_words_left = scan_words_left - 16'd1;
        if (scan_index == 16'(spirv_lss_pkg::IDX_MODE))
          scan_local_size = (w == spirv_lss_pkg::MODE_LOCAL_SIZE);
        else if (scan_index >= 16'(spirv_lss_pkg::IDX_SIZE_X) &&
                 scan_index <= 16'(spirv_lss_pkg::IDX_SIZE_Z))
          scan_staged[2'(scan_index - 16'(spirv_lss_pkg::IDX_SIZE_X))] = w;
        // Sizes count only once the whole instruction has arrived.
        if (scan_words_left == 16'd0 && scan_exec_mode && scan_local_size) begin
          scan_sizes   = scan_staged;
          scan_found   = 1'b1;
          scan_stopped = 1'b1;
        end
      end
    end
    if (last) begin
      res.size_x = scan_sizes[0];
      res.size_y = scan_sizes[1];
      res.size_z = scan_sizes[2];
      res.found  = scan_found;
      sizes_expected_q.push_back(res);
      clear_scan_state();
    end
  endfunction

  // Valid is only lowered when an idle cycle follows, so it never toggles
  // twice in one step between back-to-back requests.
  task automatic send_word(input logic [31:0] w, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.code_word     <= w;
    in_if.end_of_module <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_local_size(w, last);
    words_accepted++;
  endtask

  task automatic send_module();
    for (int i = 0; i < module_words.size(); i++)
      send_word(module_words[i], i == module_words.size() - 1);
  endtask

  function automatic void begin_module(input logic [31:0] first);
    module_words.delete();
    module_words.push_back(first);
    repeat (4) module_words.push_back($urandom);
  endfunction

  function automatic void push_local_size(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input int extra);
    module_words.push_back({16'(6 + extra), spirv_lss_pkg::OP_EXEC_MODE});
    module_words.push_back($urandom);
    module_words.push_back(spirv_lss_pkg::MODE_LOCAL_SIZE);
    module_words.push_back(x);
    module_words.push_back(y);
    module_words.push_back(z);
    repeat (extra) module_words.push_back($urandom);
  endfunction

  task automatic test_short_modules();
    // A module that ends on its magic word.
    module_words.delete();
    module_words.push_back(spirv_lss_pkg::MAGIC_WORD);
    send_module();
    // Wrong magic: everything after the header is ignored.
    begin_module(spirv_lss_pkg::MAGIC_WORD ^ 32'h8000_0001);
    module_words.push_back({16'd0, 16'hFFFF});
    send_module();
  endtask

  task automatic test_local_size_found();
    // Extreme sizes; the second LocalSize comes after the find and is ignored.
    begin_module(spirv_lss_pkg::MAGIC_WORD);
    push_local_size(32'h0, 32'hFFFF_FFFF, 32'h1, 0);
    push_local_size(32'd5, 32'd5, 32'd5, 0);
    send_module();
    // A LocalSize mode in an execution mode that is too short does not count;
    // a longer one that follows does.
    begin_module(spirv_lss_pkg::MAGIC_WORD);
    module_words.push_back({16'd5, spirv_lss_pkg::OP_EXEC_MODE});
    module_words.push_back($urandom);
    module_words.push_back(spirv_lss_pkg::MODE_LOCAL_SIZE);
    module_words.push_back(32'd9);
    module_words.push_back(32'd9);
    push_local_size(32'h8000_0000, 32'h7FFF_FFFF, 32'd64, 2);
    send_module();
  endtask

  task automatic test_scan_stops();
    // A zero length header halts the scan.
    begin_module(spirv_lss_pkg::MAGIC_WORD);
    module_words.push_back({16'd0, spirv_lss_pkg::OP_EXEC_MODE});
    push_local_size(32'd2, 32'd3, 32'd4, 0);
    send_module();
    // LocalSize cut off by the end of the module.
    begin_module(spirv_lss_pkg::MAGIC_WORD);
    push_local_size(32'd7, 32'd8, 32'd9, 1);
    void'(module_words.pop_back());
    void'(module_words.pop_back());
    send_module();
  endtask

  task automatic send_random_module();
    int kind;
    int len;
    int keep;
    logic [15:0] opc;
    kind = int'($urandom_range(99));
    if (kind < 10) begin
      module_words.delete();
      repeat ($urandom_range(1, 20)) module_words.push_back($urandom);
    end else begin
      begin_module(kind < 18 ? $urandom : spirv_lss_pkg::MAGIC_WORD);
      repeat ($urandom_range(0, 3)) begin
        len = int'($urandom_range(1, 8));
        opc = ($urandom_range(2) == 0) ? spirv_lss_pkg::OP_EXEC_MODE : 16'($urandom);
        module_words.push_back({16'(len), opc});
        for (int i = 1; i < len; i++)
          module_words.push_back((i == int'(spirv_lss_pkg::IDX_MODE) &&
                                  $urandom_range(1) == 1) ?
                                 spirv_lss_pkg::MODE_LOCAL_SIZE : $urandom);
      end
      if ($urandom_range(19) == 0) module_words.push_back({16'd0, 16'($urandom)});
      if ($urandom_range(9) < 7)
        push_local_size($urandom, $urandom, $urandom, int'($urandom_range(0, 2)));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) module_words.push_back($urandom);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3))
          if (module_words.size() > 1) void'(module_words.pop_back());
      if (kind < 25) begin
        keep = int'($urandom_range(1, 6));
        while (module_words.size() > keep) void'(module_words.pop_back());
      end
    end
    send_module();
  endtask

  task automatic test_random_traffic(input int in_idle, input int out_stall,
                                     input int n_words);
    int target;
    target = words_accepted + n_words;
    idle_pct = in_idle;
    stall_pct <= out_stall;
    while (words_accepted < target) send_random_module();
  endtask

  // The receiver holds off while one-word modules keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct <= 0;
    -> hold_start;
    repeat (30) send_word($urandom_range(1) ? spirv_lss_pkg::MAGIC_WORD : $urandom, 1'b1);
  endtask

  initial begin
    holding <= 1'b0;
    forever begin
      @(hold_start);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !holding && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    spirv_lss_pkg::out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sizes_expected_q.size() == 0) begin
        report_mismatch("result with none expected", out_if.size_x, 32'd0);
      end else begin
        want = sizes_expected_q.pop_front();
        if (out_if.size_x !== want.size_x) report_mismatch("size_x", out_if.size_x, want.size_x);
        if (out_if.size_y !== want.size_y) report_mismatch("size_y", out_if.size_y, want.size_y);
        if (out_if.size_z !== want.size_z) report_mismatch("size_z", out_if.size_z, want.size_z);
        if (out_if.found !== want.found)
          report_mismatch("found", 32'(out_if.found), 32'(want.found));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int drain_cycles;
    words_accepted = 0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct <= 0;
    clear_scan_state();
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.code_word <= '0;
    in_if.end_of_module <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_short_modules();
    test_local_size_found();
    test_scan_stops();
    test_random_traffic(0, 0, 370);
    test_random_traffic(79, 0, 370);
    test_random_traffic(0, 79, 370);
    test_random_traffic(22, 22, 370);
    test_backpressure();

    in_if.valid <= 1'b0;
    stall_pct <= 0;
    drain_cycles = 0;
    while (sizes_expected_q.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (sizes_expected_q.size() != 0)
      report_mismatch("results never delivered", 32'(sizes_expected_q.size()), 32'd0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ spirv_local_size_scanner_unit.f @@
sv/spirv_lss_pkg.sv
sv/spirv_lss_if.sv
sv/spirv_lss_in_stage.sv
sv/spirv_lss_core.sv
sv/spirv_local_size_scanner_unit.sv
sv/spirv_lss_checker.sv
dv/tb_top.sv
